### src/urh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urh_pkg: shared types and constants of the undo/redo history ring
// Command codes, field widths, parameter defaults and the control/status
// structs between the controller and the datapath.
// ----------------------------------------------------------------------------
package urh_pkg;

    // Parameter defaults
    localparam int DEPTH_DEF        = 16;
    localparam int PAYLOAD_BITS_DEF = 32;

    // Fixed field widths
    localparam int FUNC_BITS     = 3;
    localparam int TYPE_BITS     = 4;
    localparam int PAY_PORT_BITS = 32;

    // Command codes
    localparam logic [FUNC_BITS-1:0] FUNC_CLEAR = 3'd0;
    localparam logic [FUNC_BITS-1:0] FUNC_ADD   = 3'd1;
    localparam logic [FUNC_BITS-1:0] FUNC_REDO  = 3'd2;
    localparam logic [FUNC_BITS-1:0] FUNC_UNDO  = 3'd3;
    localparam logic [FUNC_BITS-1:0] FUNC_MARK  = 3'd4;

    // History RAM read address select
    typedef logic [1:0] rd_sel_t;
    localparam rd_sel_t RD_CUR  = 2'd0;
    localparam rd_sel_t RD_NXT  = 2'd1;
    localparam rd_sel_t RD_WALK = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic    take_req;
        logic    sweep_init;
        logic    sweep_wr;
        rd_sel_t rd_sel;
        logic    wr_new;
        logic    wipe_wr;
        logic    redo_step;
        logic    undo_step;
        logic    mark_save;
        logic    cap_cur;
        logic    load_out;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic sweep_last;
        logic equal;
        logic nxt_ok;
        logic wipe_stop;
        logic out_busy;
    } sts_t;

endpackage

### src/urh_cmd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urh_cmd_if: command channel of the history ring
// Valid/ready channel that carries one command request.
// ----------------------------------------------------------------------------
interface urh_cmd_if;

    logic                              valid;
    logic                              ready;
    logic [urh_pkg::FUNC_BITS-1:0]     func;
    logic [urh_pkg::TYPE_BITS-1:0]     entry_type;
    logic [urh_pkg::PAY_PORT_BITS-1:0] entry_payload;

    modport source (output valid, output func, output entry_type, output entry_payload,
                    input ready);
    modport sink   (input valid, input func, input entry_type, input entry_payload,
                    output ready);

endinterface

### src/urh_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urh_rsp_if: response channel of the history ring
// Valid/ready channel that carries the current entry and status flags.
// ----------------------------------------------------------------------------
interface urh_rsp_if;

    logic                              valid;
    logic                              ready;
    logic [urh_pkg::TYPE_BITS-1:0]     current_type;
    logic [urh_pkg::PAY_PORT_BITS-1:0] current_payload;
    logic                              can_redo;
    logic                              can_undo;
    logic                              at_saved;

    modport source (output valid, output current_type, output current_payload,
                    output can_redo, output can_undo, output at_saved, input ready);
    modport sink   (input valid, input current_type, input current_payload,
                    input can_redo, input can_undo, input at_saved, output ready);

endinterface

### src/urh_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urh_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module urh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### src/urh_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urh_ctrl: history ring controller
// Sequences clear sweeps, add with redo wipe, redo/undo/mark and the
// two-read status report for every request.
// ----------------------------------------------------------------------------
module urh_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [urh_pkg::FUNC_BITS-1:0] in_func,
    output logic                          in_ready,
    input  urh_pkg::sts_t                 sts,
    output urh_pkg::cmd_t                 cmd
);

    localparam logic [3:0] S_INIT     = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_CLR      = 4'd2;
    localparam logic [3:0] S_ADD_CMP  = 4'd3;
    localparam logic [3:0] S_WIPE_RD  = 4'd4;
    localparam logic [3:0] S_WIPE_CHK = 4'd5;
    localparam logic [3:0] S_REDO_RD  = 4'd6;
    localparam logic [3:0] S_REDO_CHK = 4'd7;
    localparam logic [3:0] S_REP_A    = 4'd8;
    localparam logic [3:0] S_REP_B    = 4'd9;
    localparam logic [3:0] S_REP_C    = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    // State register; reset starts the RAM clearing sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        cmd        = '0;
        cmd.rd_sel = urh_pkg::RD_CUR;
        in_ready   = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            S_INIT:
            begin
                cmd.sweep_wr = 1'b1;
                if (sts.sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.take_req = 1'b1;
                    unique case (in_func)
                        urh_pkg::FUNC_CLEAR:
                        begin
                            cmd.sweep_init = 1'b1;
                            state_next     = S_CLR;
                        end
                        urh_pkg::FUNC_ADD:  state_next = S_ADD_CMP;
                        urh_pkg::FUNC_REDO: state_next = S_REDO_RD;
                        urh_pkg::FUNC_UNDO:
                        begin
                            cmd.undo_step = 1'b1;
                            state_next    = S_REP_A;
                        end
                        urh_pkg::FUNC_MARK:
                        begin
                            cmd.mark_save = 1'b1;
                            state_next    = S_REP_A;
                        end
                        default: state_next = S_REP_A;
                    endcase
                end
            end
            S_CLR:
            begin
                cmd.sweep_wr = 1'b1;
                if (sts.sweep_last)
                begin
                    state_next = S_REP_A;
                end
            end
            // Current entry was read at accept; skip add of an equal entry
            S_ADD_CMP:
            begin
                if (sts.equal)
                begin
                    state_next = S_REP_A;
                end
                else
                begin
                    cmd.wr_new = 1'b1;
                    state_next = S_WIPE_RD;
                end
            end
            S_WIPE_RD:
            begin
                cmd.rd_sel = urh_pkg::RD_WALK;
                state_next = S_WIPE_CHK;
            end
            S_WIPE_CHK:
            begin
                cmd.rd_sel = urh_pkg::RD_WALK;
                if (sts.wipe_stop)
                begin
                    state_next = S_REP_A;
                end
                else
                begin
                    cmd.wipe_wr = 1'b1;
                    state_next  = S_WIPE_RD;
                end
            end
            S_REDO_RD:
            begin
                cmd.rd_sel = urh_pkg::RD_NXT;
                state_next = S_REDO_CHK;
            end
            S_REDO_CHK:
            begin
                cmd.rd_sel    = urh_pkg::RD_NXT;
                cmd.redo_step = sts.nxt_ok;
                state_next    = S_REP_A;
            end
            // Report: read cursor slot, then next slot for the redo flag
            S_REP_A:
            begin
                state_next = S_REP_B;
            end
            S_REP_B:
            begin
                cmd.rd_sel  = urh_pkg::RD_NXT;
                cmd.cap_cur = 1'b1;
                state_next  = S_REP_C;
            end
            S_REP_C:
            begin
                cmd.rd_sel = urh_pkg::RD_NXT;
                if (!sts.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

### src/urh_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urh_dpath: history ring datapath
// Pointer registers, history RAM, request latch and response register.
// ----------------------------------------------------------------------------
module urh_dpath #(
    parameter int DEPTH        = urh_pkg::DEPTH_DEF,
    parameter int PAYLOAD_BITS = urh_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  urh_pkg::cmd_t                     cmd,
    output urh_pkg::sts_t                     sts,
    input  logic [urh_pkg::TYPE_BITS-1:0]     in_type,
    input  logic [urh_pkg::PAY_PORT_BITS-1:0] in_payload,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [urh_pkg::TYPE_BITS-1:0]     out_type,
    output logic [urh_pkg::PAY_PORT_BITS-1:0] out_payload,
    output logic                              out_can_redo,
    output logic                              out_can_undo,
    output logic                              out_at_saved
);

    localparam int AW   = $clog2(DEPTH);
    localparam int KEEP = (PAYLOAD_BITS < urh_pkg::PAY_PORT_BITS) ?
                          PAYLOAD_BITS : urh_pkg::PAY_PORT_BITS;
    localparam int TW   = urh_pkg::TYPE_BITS;
    localparam int EW   = TW + KEEP;
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] k);
        return (k == LAST) ? '0 : k + 1'b1;
    endfunction

    function automatic logic [AW-1:0] prev_slot(input logic [AW-1:0] k);
        return (k == '0) ? LAST : k - 1'b1;
    endfunction

    logic [AW-1:0]   cursor_reg;
    logic [AW-1:0]   oldest_reg;
    logic [AW-1:0]   saved_slot_reg;
    logic            saved_valid_reg;
    logic [AW-1:0]   walk_reg;
    logic [TW-1:0]   req_type_reg;
    logic [KEEP-1:0] req_pay_reg;
    logic [TW-1:0]   cap_type_reg;
    logic [KEEP-1:0] cap_pay_reg;
    logic            out_valid_reg;
    logic [TW-1:0]   out_type_reg;
    logic [urh_pkg::PAY_PORT_BITS-1:0] out_pay_reg;
    logic            out_redo_reg;
    logic            out_undo_reg;
    logic            out_saved_reg;

    logic [AW-1:0]   cursor_nx;
    logic [AW-1:0]   rd_addr;
    logic [AW-1:0]   wr_addr;
    logic [EW-1:0]   wr_data;
    logic            wr_en;
    logic [EW-1:0]   rd_data;
    logic [TW-1:0]   rd_type;
    logic [KEEP-1:0] rd_pay;

    assign cursor_nx = next_slot(cursor_reg);
    assign rd_type   = rd_data[EW-1 -: TW];
    assign rd_pay    = rd_data[KEEP-1:0];

    // RAM port muxing
    always_comb
    begin
        case (cmd.rd_sel)
            urh_pkg::RD_CUR:  rd_addr = cursor_reg;
            urh_pkg::RD_NXT:  rd_addr = cursor_nx;
            urh_pkg::RD_WALK: rd_addr = walk_reg;
            default:          rd_addr = cursor_reg;
        endcase
    end

    assign wr_en   = cmd.sweep_wr | cmd.wr_new | cmd.wipe_wr;
    assign wr_addr = cmd.wr_new ? cursor_nx : walk_reg;

    always_comb
    begin
        if (cmd.wr_new)
        begin
            wr_data = {req_type_reg, req_pay_reg};
        end
        else if (cmd.wipe_wr)
        begin
            wr_data = {TW'(0), rd_pay};
        end
        else
        begin
            wr_data = '0;
        end
    end

    urh_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_hist_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // Status to controller
    assign sts.sweep_last = (walk_reg == LAST);
    assign sts.equal      = (rd_type == req_type_reg) && (rd_pay == req_pay_reg);
    assign sts.nxt_ok     = (cursor_nx != oldest_reg) && (rd_type != '0);
    assign sts.wipe_stop  = (walk_reg == oldest_reg) || (rd_type == '0);
    assign sts.out_busy   = out_valid_reg && !out_ready;

    // Ring pointers and saved mark
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg      <= '0;
            oldest_reg      <= '0;
            saved_slot_reg  <= '0;
            saved_valid_reg <= 1'b1;
            walk_reg        <= '0;
        end
        else if (cmd.sweep_init)
        begin
            cursor_reg      <= '0;
            oldest_reg      <= '0;
            saved_slot_reg  <= '0;
            saved_valid_reg <= 1'b1;
            walk_reg        <= '0;
        end
        else if (cmd.sweep_wr)
        begin
            walk_reg <= next_slot(walk_reg);
        end
        else if (cmd.wr_new)
        begin
            // advance cursor; push oldest and drop saved mark when overwritten
            cursor_reg <= cursor_nx;
            walk_reg   <= next_slot(cursor_nx);
            if (cursor_nx == oldest_reg)
            begin
                oldest_reg <= next_slot(oldest_reg);
            end
            if (saved_valid_reg && (saved_slot_reg == cursor_nx))
            begin
                saved_valid_reg <= 1'b0;
            end
        end
        else if (cmd.wipe_wr)
        begin
            walk_reg <= next_slot(walk_reg);
            if (saved_valid_reg && (saved_slot_reg == walk_reg))
            begin
                saved_valid_reg <= 1'b0;
            end
        end
        else if (cmd.redo_step)
        begin
            cursor_reg <= cursor_nx;
        end
        else if (cmd.undo_step)
        begin
            if (cursor_reg != oldest_reg)
            begin
                cursor_reg <= prev_slot(cursor_reg);
            end
        end
        else if (cmd.mark_save)
        begin
            saved_slot_reg  <= cursor_reg;
            saved_valid_reg <= 1'b1;
        end
    end

    // Request latch, captured entry and response payload
    always_ff @(posedge clk)
    begin
        if (cmd.take_req)
        begin
            req_type_reg <= in_type;
            req_pay_reg  <= in_payload[KEEP-1:0];
        end
        if (cmd.cap_cur)
        begin
            cap_type_reg <= rd_type;
            cap_pay_reg  <= rd_pay;
        end
        if (cmd.load_out)
        begin
            out_type_reg  <= cap_type_reg;
            out_pay_reg   <= urh_pkg::PAY_PORT_BITS'(cap_pay_reg);
            out_redo_reg  <= sts.nxt_ok;
            out_undo_reg  <= (cursor_reg != oldest_reg);
            out_saved_reg <= saved_valid_reg && (saved_slot_reg == cursor_reg);
        end
    end

    // Response valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_type     = out_type_reg;
    assign out_payload  = out_pay_reg;
    assign out_can_redo = out_redo_reg;
    assign out_can_undo = out_undo_reg;
    assign out_at_saved = out_saved_reg;

    // An add never leaves the cursor on the oldest slot
    a_add_cursor_oldest: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_new |=> (cursor_reg != oldest_reg))
        else $error("cursor equals oldest after add");

    // The redo wipe never touches the current slot
    a_wipe_not_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wipe_wr |-> (walk_reg != cursor_reg))
        else $error("redo wipe hit cursor slot");

    // A pending response is never overwritten
    a_no_resp_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !(out_valid_reg && !out_ready))
        else $error("response register overrun");

    // Redo only steps when the next slot is live
    a_redo_gated: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.redo_step |-> (cursor_nx != oldest_reg))
        else $error("redo stepped onto oldest slot");

endmodule

### src/undo_redo_history_ring_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// undo_redo_history_ring_unit: undo/redo history ring
// Ring of DEPTH history entries with cursor, oldest slot and saved mark.
// ----------------------------------------------------------------------------
// One request at a time, one response per request. After reset the history
// RAM is swept to zero, during which no request is taken. Each request ends
// with a status report that reads the cursor slot and then the next slot; a
// clear first sweeps the RAM, and an add of an entry that is not equal to the
// current one then wipes the redo slots one at a time, each read and then
// checked, as the history RAM has a single read port. A new request is taken
// as soon as the response is loaded, even while it still waits to be taken.
module undo_redo_history_ring_unit #(
    parameter int DEPTH        = urh_pkg::DEPTH_DEF,
    parameter int PAYLOAD_BITS = urh_pkg::PAYLOAD_BITS_DEF
) (
    input logic     clk,
    input logic     rst_n,
    urh_cmd_if.sink   cmd,
    urh_rsp_if.source rsp
);

    urh_pkg::cmd_t ctl_cmd;
    urh_pkg::sts_t ctl_sts;
    logic          in_ready;

    assign cmd.ready = in_ready;

    urh_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cmd.valid),
        .in_func  (cmd.func),
        .in_ready (in_ready),
        .sts      (ctl_sts),
        .cmd      (ctl_cmd)
    );

    urh_dpath #(
        .DEPTH        (DEPTH),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (ctl_cmd),
        .sts          (ctl_sts),
        .in_type      (cmd.entry_type),
        .in_payload   (cmd.entry_payload),
        .out_valid    (rsp.valid),
        .out_ready    (rsp.ready),
        .out_type     (rsp.current_type),
        .out_payload  (rsp.current_payload),
        .out_can_redo (rsp.can_redo),
        .out_can_undo (rsp.can_undo),
        .out_at_saved (rsp.at_saved)
    );

endmodule

### tb/urh_history_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urh_history_checker: response checker for the undo/redo history ring
// Watches the command and response channels, keeps its own copy of the ring
// (slots, cursor, oldest slot, saved mark) and compares every response,
// field by field, with the status predicted for the matching request.
// ----------------------------------------------------------------------------
module urh_history_checker
    import urh_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    urh_cmd_if   cmd,
    urh_rsp_if   rsp,
    output int   fail_count,
    output int   pending
);

    localparam int DEPTH     = DEPTH_DEF;
    localparam int SLOT_BITS = $clog2(DEPTH);
    localparam logic [PAY_PORT_BITS-1:0] PAY_MASK =
        {PAY_PORT_BITS{1'b1}} >> (PAY_PORT_BITS - PAYLOAD_BITS_DEF);

    typedef logic [SLOT_BITS-1:0] slot_t;

    typedef struct packed {
        logic [TYPE_BITS-1:0]     cur_type;
        logic [PAY_PORT_BITS-1:0] cur_payload;
        logic                     redo_ok;
        logic                     undo_ok;
        logic                     on_saved;
    } ring_status_t;

    // Shadow copy of the ring
    logic [TYPE_BITS-1:0]     hist_type [DEPTH];
    logic [PAY_PORT_BITS-1:0] hist_pay  [DEPTH];
    slot_t                    cur;
    slot_t                    oldest_slot;
    slot_t                    saved_slot;
    logic                     saved_ok;

    // Statuses waiting for their response, oldest first
    ring_status_t status_q [$];

    function automatic slot_t next_slot(input slot_t s);
        return (s == slot_t'(DEPTH - 1)) ? '0 : s + 1'b1;
    endfunction

    function automatic slot_t prev_slot(input slot_t s);
        return (s == '0) ? slot_t'(DEPTH - 1) : s - 1'b1;
    endfunction

    function automatic logic redo_open();
        slot_t nx;
        nx = next_slot(cur);
        return (nx != oldest_slot) && (hist_type[nx] != '0);
    endfunction

    function automatic void clear_history();
        for (int k = 0; k < DEPTH; k++)
        begin
            hist_type[k] = '0;
            hist_pay[k]  = '0;
        end
        cur         = '0;
        oldest_slot = '0;
        saved_slot  = '0;
        saved_ok    = 1'b1;
    endfunction

    // Add: skip a repeat of the current entry, else write and wipe redo slots
    function automatic void add_entry(input logic [TYPE_BITS-1:0] t,
                                      input logic [PAY_PORT_BITS-1:0] p);
        slot_t j;
        if (hist_type[cur] == t && hist_pay[cur] == p)
            return;
        cur           = next_slot(cur);
        hist_type[cur] = t;
        hist_pay[cur]  = p;
        if (cur == oldest_slot)
            oldest_slot = next_slot(oldest_slot);
        if (saved_ok && saved_slot == cur)
            saved_ok = 1'b0;
        j = cur;
        for (int g = 0; g < DEPTH; g++)
        begin
            j = next_slot(j);
            if (j == oldest_slot || hist_type[j] == '0)
                break;
            hist_type[j] = '0;
            if (saved_ok && saved_slot == j)
                saved_ok = 1'b0;
        end
    endfunction

    function automatic ring_status_t apply_request(input logic [FUNC_BITS-1:0] f,
                                                   input logic [TYPE_BITS-1:0] t,
                                                   input logic [PAY_PORT_BITS-1:0] p);
        ring_status_t s;
        case (f)
            FUNC_CLEAR: clear_history();
            FUNC_ADD:   add_entry(t, p & PAY_MASK);
            FUNC_REDO:  if (redo_open()) cur = next_slot(cur);
            FUNC_UNDO:  if (cur != oldest_slot) cur = prev_slot(cur);
            FUNC_MARK:
            begin
                saved_slot = cur;
                saved_ok   = 1'b1;
            end
            default:    ;
        endcase
        s.cur_type    = hist_type[cur];
        s.cur_payload = hist_pay[cur];
        s.redo_ok     = redo_open();
        s.undo_ok     = (cur != oldest_slot);
        s.on_saved    = saved_ok && (saved_slot == cur);
        return s;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch: expected %h actual %h", $time, name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // Responses are checked before the request of the same edge is predicted
    always @(posedge clk or negedge rst_n)
    begin
        ring_status_t want;
        if (!rst_n)
        begin
            clear_history();
            status_q.delete();
            fail_count = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (status_q.size() == 0)
                begin
                    $display("%0t: response with no request pending: expected none actual %h/%h",
                             $time, rsp.current_type, rsp.current_payload);
                    fail_count++;
                end
                else
                begin
                    want = status_q.pop_front();
                    check_field("current_type", 32'(want.cur_type), 32'(rsp.current_type));
                    check_field("current_payload", want.cur_payload, rsp.current_payload);
                    check_field("can_redo", 32'(want.redo_ok), 32'(rsp.can_redo));
                    check_field("can_undo", 32'(want.undo_ok), 32'(rsp.can_undo));
                    check_field("at_saved", 32'(want.on_saved), 32'(rsp.at_saved));
                end
            end
            if (cmd.valid && cmd.ready)
                status_q.push_back(apply_request(cmd.func, cmd.entry_type, cmd.entry_payload));
        end
        pending = status_q.size();
    end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench top for the undo/redo history ring
// Drives a directed set of editor commands, then random command sequences
// (add runs, undo/redo runs, wraps past the ring size) with random idling on
// both channels; the checker predicts and compares every response.
// ----------------------------------------------------------------------------
module tb;
    import urh_pkg::*;

    localparam int          TOTAL_REQS   = 1450;
    localparam int          CALM_REQS    = 150;
    localparam int unsigned LIMIT_CYCLES = 400000;
    localparam int          SETTLE       = 60;

    // Command codes the block does not define
    localparam logic [FUNC_BITS-1:0] FUNC_SPARE_FIRST = 3'd5;
    localparam logic [FUNC_BITS-1:0] FUNC_SPARE_LAST  = 3'd7;

    logic        clk;
    logic        rst_n;
    int          fail_count;
    int          pending;
    int unsigned cycles = 0;
    int          reqs_sent = 0;
    int          idle_odds = 4;

    urh_cmd_if cmd ();
    urh_rsp_if rsp ();

    undo_redo_history_ring_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .rsp   (rsp)
    );

    urh_history_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .rsp        (rsp),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Response side: random stall bursts while idle_odds is nonzero
    initial
    begin
        int stall;
        stall     = 0;
        rsp.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (idle_odds == 0)
                rsp.ready <= 1'b1;
            else if (stall > 0)
            begin
                rsp.ready <= 1'b0;
                stall--;
            end
            else if ($urandom_range(1, idle_odds) == 1)
            begin
                stall = $urandom_range(0, 10);
                rsp.ready <= 1'b0;
            end
            else
                rsp.ready <= 1'b1;
        end
    end

    // One request; called and returns at a falling edge
    task automatic send_req(input logic [FUNC_BITS-1:0] f, input logic [TYPE_BITS-1:0] t,
                            input logic [PAY_PORT_BITS-1:0] p);
        int gap;
        if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
        begin
            gap = $urandom_range(1, 11);
            cmd.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd.valid         <= 1'b1;
        cmd.func          <= f;
        cmd.entry_type    <= t;
        cmd.entry_payload <= p;
        @(posedge clk);
        while (!cmd.ready)
            @(posedge clk);
        reqs_sent++;
        @(negedge clk);
    endtask

    // Hold requests back until every response is in
    task automatic drain_responses();
        cmd.valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
    endtask

    // Half the entries come from a tiny pool so repeats of the current entry occur
    task automatic rand_entry(output logic [TYPE_BITS-1:0] t,
                              output logic [PAY_PORT_BITS-1:0] p);
        if ($urandom_range(0, 1) == 0)
        begin
            t = TYPE_BITS'($urandom_range(0, 3));
            p = PAY_PORT_BITS'($urandom_range(0, 3));
        end
        else
        begin
            t = TYPE_BITS'($urandom);
            p = $urandom;
        end
    endtask

    function automatic logic [FUNC_BITS-1:0] pick_func();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return FUNC_ADD;
        else if (r < 60)
            return FUNC_UNDO;
        else if (r < 78)
            return FUNC_REDO;
        else if (r < 88)
            return FUNC_MARK;
        else if (r < 93)
            return FUNC_CLEAR;
        return FUNC_BITS'($urandom_range(FUNC_SPARE_FIRST, FUNC_SPARE_LAST));
    endfunction

    initial
    begin
        logic [TYPE_BITS-1:0]     t;
        logic [PAY_PORT_BITS-1:0] p;
        int                       pick;
        int                       n;

        rst_n             = 1'b0;
        cmd.valid         = 1'b0;
        cmd.func          = FUNC_CLEAR;
        cmd.entry_type    = '0;
        cmd.entry_payload = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: repeats, bounds of undo/redo, type-0 entries, saved mark, spares
        send_req(FUNC_ADD,  4'd0,  32'h0000_0000);
        send_req(FUNC_UNDO, 4'd0,  32'h0000_0000);
        send_req(FUNC_REDO, 4'd0,  32'h0000_0000);
        send_req(FUNC_ADD,  4'd15, 32'hFFFF_FFFF);
        send_req(FUNC_ADD,  4'd15, 32'hFFFF_FFFF);
        send_req(FUNC_ADD,  4'd1,  32'h0000_0000);
        send_req(FUNC_ADD,  4'd0,  32'h5A5A_5A5A);
        send_req(FUNC_MARK, 4'd15, 32'hFFFF_FFFF);
        send_req(FUNC_UNDO, 4'd0,  32'h0000_0000);
        send_req(FUNC_UNDO, 4'd0,  32'h0000_0000);
        send_req(FUNC_REDO, 4'd0,  32'h0000_0000);
        send_req(FUNC_REDO, 4'd0,  32'h0000_0000);
        send_req(FUNC_UNDO, 4'd0,  32'h0000_0000);
        send_req(FUNC_ADD,  4'd8,  32'h0000_0001);
        send_req(FUNC_MARK, 4'd0,  32'h0000_0000);
        send_req(FUNC_UNDO, 4'd0,  32'h0000_0000);
        send_req(FUNC_UNDO, 4'd0,  32'h0000_0000);
        send_req(FUNC_ADD,  4'd2,  32'h8000_0000);
        for (int f = FUNC_SPARE_FIRST; f <= FUNC_SPARE_LAST; f++)
            send_req(FUNC_BITS'(f), 4'd9, 32'hA5A5_A5A5);
        send_req(FUNC_CLEAR, 4'd3, 32'h1234_5678);
        send_req(FUNC_MARK,  4'd0, 32'h0000_0000);
        drain_responses();

        // Random command sequences
        while (reqs_sent < TOTAL_REQS)
        begin
            if (reqs_sent >= TOTAL_REQS - CALM_REQS)
                idle_odds = 0;
            else if ($urandom_range(0, 9) == 0)
                idle_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(3, 8);

            pick = $urandom_range(0, 99);
            if (pick < 60)
            begin
                rand_entry(t, p);
                send_req(pick_func(), t, p);
            end
            else if (pick < 72)
            begin
                // back up through history, then branch off
                n = $urandom_range(1, 17);
                repeat (n) send_req(FUNC_UNDO, TYPE_BITS'($urandom), $urandom);
                rand_entry(t, p);
                send_req(FUNC_ADD, t, p);
            end
            else if (pick < 84)
            begin
                n = $urandom_range(1, 20);
                repeat (n)
                begin
                    rand_entry(t, p);
                    send_req(FUNC_ADD, t, p);
                end
            end
            else if (pick < 92)
            begin
                n = $urandom_range(1, 17);
                repeat (n) send_req(FUNC_REDO, TYPE_BITS'($urandom), $urandom);
            end
            else if (pick < 97)
            begin
                // mark, then wrap the ring so the marked slot gets overwritten
                send_req(FUNC_MARK, '0, '0);
                repeat ($urandom_range(16, 20))
                    send_req(FUNC_ADD, TYPE_BITS'($urandom_range(1, 15)), $urandom);
            end
            else if (idle_odds != 0)
                drain_responses();
        end

        drain_responses();
        repeat (SETTLE) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
